// ===== design/pba_pkg.sv =====
// Shared types, codes and constants of the packed bit-field array engine.
`timescale 1ns / 1ps

package pba_pkg;

    localparam int          PBA_MEM_WORDS = 1024;
    localparam int          WORD_BITS     = 32;
    localparam logic [4:0]  K_RESET       = 5'd8;

    // action codes
    localparam logic [3:0] ACT_READ     = 4'd0;
    localparam logic [3:0] ACT_WRITE    = 4'd1;
    localparam logic [3:0] ACT_OR       = 4'd2;
    localparam logic [3:0] ACT_AND      = 4'd3;
    localparam logic [3:0] ACT_XOR      = 4'd4;
    localparam logic [3:0] ACT_APPEND   = 4'd5;
    localparam logic [3:0] ACT_INS_ZERO = 4'd6;
    localparam logic [3:0] ACT_INS_VAL  = 4'd7;
    localparam logic [3:0] ACT_REMOVE   = 4'd8;
    localparam logic [3:0] ACT_CLEAR    = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_WIDE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SRC,
        S_DST,
        S_WR,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_FIELD,
        PH_DOWN,
        PH_UP,
        PH_FILL
    } phase_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_GROW,
        UPD_SHRINK
    } upd_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic [30:0] read_data;
        logic [15:0] item_count;
        logic [1:0]  status;
    } res_t;

endpackage

// ===== design/packed_bitfield_array_engine.sv =====
// Top level of the packed bit-field array engine.
`timescale 1ns / 1ps

// Holds an array of k-bit items (k from 1 to 31, written through the config
// port, reset 8) packed back to back, LSB first, in MEM_WORDS 32-bit words;
// an item may straddle two words. Each request returns exactly one result
// with the value read, the item count after the request and a status. Any
// write to the config port with a non-zero width empties the array. The
// words sit in two single-port banks (even and odd words), so an item and
// its neighbour word are read, or written, in one access; every change to
// an item is a read followed by a merged write. Insert and remove move the
// tail one item at a time (source read, destination read, write), and
// insert fills each new item with a destination read and a write. Stale
// words above the fill point are never read back, so reset and clear only
// drop the fill count and need no sweep. A new request is taken while the
// previous result still waits in the output register.

module packed_bitfield_array_engine import pba_pkg::*; #(
    parameter int MEM_WORDS = PBA_MEM_WORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [4:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  action,
    input  logic [14:0] index,
    input  logic [30:0] value,
    input  logic [15:0] count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] read_data,
    output logic [15:0] item_count,
    output logic [1:0]  status
);

    localparam int WORD_W = $clog2(MEM_WORDS);

    logic [4:0]  k_reg;
    logic        cfg_clear;
    logic        out_valid_reg;
    res_t        res_reg;
    res_t        res;
    logic        done;
    logic        out_free;
    mem_ctl_t    mem_ctl;
    logic [WORD_W-1:0]    mem_word;
    logic [WORD_BITS-1:0] mem_wr_lo;
    logic [WORD_BITS-1:0] mem_wr_hi;
    logic [WORD_BITS-1:0] mem_rd_lo;
    logic [WORD_BITS-1:0] mem_rd_hi;

    // a zero width is dropped; any other width empties the array
    assign cfg_clear = cfg_write_en && (cfg_write_data != '0);

    // the output slot frees when empty or when its result is taken now
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= K_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_clear)
            begin
                k_reg <= cfg_write_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the consumer takes it
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = res_reg.read_data;
    assign item_count = res_reg.item_count;
    assign status     = res_reg.status;

    pba_ctrl #(
        .MEM_WORDS (MEM_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .k         (k_reg),
        .cfg_clear (cfg_clear),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .index     (index),
        .value     (value),
        .count     (count),
        .out_free  (out_free),
        .done      (done),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .mem_word  (mem_word),
        .mem_wr_lo (mem_wr_lo),
        .mem_wr_hi (mem_wr_hi),
        .mem_rd_lo (mem_rd_lo),
        .mem_rd_hi (mem_rd_hi)
    );

    pba_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .word  (mem_word),
        .wr_lo (mem_wr_lo),
        .wr_hi (mem_wr_hi),
        .rd_lo (mem_rd_lo),
        .rd_hi (mem_rd_hi)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg != '0)
        else $error("item width is zero");

    a_done_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid_reg)
        else $error("finished request produced no result");

endmodule

// ===== design/pba_mem.sv =====
// Two-bank word store giving a word and its successor in one access.
`timescale 1ns / 1ps

module pba_mem import pba_pkg::*; #(
    parameter int MEM_WORDS = PBA_MEM_WORDS
) (
    input  logic                         clk,
    input  mem_ctl_t                     ctl,
    input  logic [$clog2(MEM_WORDS)-1:0] word,
    input  logic [WORD_BITS-1:0]         wr_lo,
    input  logic [WORD_BITS-1:0]         wr_hi,
    output logic [WORD_BITS-1:0]         rd_lo,
    output logic [WORD_BITS-1:0]         rd_hi
);

    localparam int WORD_W     = $clog2(MEM_WORDS);
    localparam int BANK_DEPTH = (MEM_WORDS + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [WORD_BITS-1:0] even_mem [BANK_DEPTH];
    logic [WORD_BITS-1:0] odd_mem  [BANK_DEPTH];

    logic [WORD_W:0]        word_inc;
    logic [BANK_AW-1:0]     even_addr;
    logic [BANK_AW-1:0]     odd_addr;
    logic                   hi_ok;
    logic                   even_we;
    logic                   odd_we;
    logic [WORD_BITS-1:0]   even_q_reg;
    logic [WORD_BITS-1:0]   odd_q_reg;
    logic                   w0_reg;
    logic                   hi_ok_reg;

    // word w lives in bank w[0] at w/2; the pair (w, w+1) always spans both banks
    assign word_inc  = {1'b0, word} + (WORD_W+1)'(1);
    assign even_addr = BANK_AW'(word_inc >> 1);
    assign odd_addr  = BANK_AW'(word >> 1);
    assign hi_ok     = (word_inc < (WORD_W+1)'(MEM_WORDS));
    assign even_we   = ctl.wr_en && (word[0] ? hi_ok : 1'b1);
    assign odd_we    = ctl.wr_en && (word[0] ? 1'b1 : hi_ok);

    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[even_addr] <= word[0] ? wr_hi : wr_lo;
        end
        if (odd_we)
        begin
            odd_mem[odd_addr] <= word[0] ? wr_lo : wr_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            even_q_reg <= even_mem[even_addr];
            odd_q_reg  <= odd_mem[odd_addr];
            w0_reg     <= word[0];
            hi_ok_reg  <= hi_ok;
        end
    end

    assign rd_lo = w0_reg ? odd_q_reg : even_q_reg;
    assign rd_hi = hi_ok_reg ? (w0_reg ? even_q_reg : odd_q_reg) : '0;

endmodule

// ===== design/pba_ctrl.sv =====
// Request sequencer: checks, read-modify-write of items and tail moves.
`timescale 1ns / 1ps

module pba_ctrl import pba_pkg::*; #(
    parameter int MEM_WORDS = PBA_MEM_WORDS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [4:0]                   k,
    input  logic                         cfg_clear,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [3:0]                   action,
    input  logic [14:0]                  index,
    input  logic [30:0]                  value,
    input  logic [15:0]                  count,
    input  logic                         out_free,
    output logic                         done,
    output res_t                         res,
    output mem_ctl_t                     mem_ctl,
    output logic [$clog2(MEM_WORDS)-1:0] mem_word,
    output logic [WORD_BITS-1:0]         mem_wr_lo,
    output logic [WORD_BITS-1:0]         mem_wr_hi,
    input  logic [WORD_BITS-1:0]         mem_rd_lo,
    input  logic [WORD_BITS-1:0]         mem_rd_hi
);

    localparam int WORD_W = $clog2(MEM_WORDS);
    localparam int POS_W  = WORD_W + 5;
    localparam int FILL_W = POS_W + 1;
    localparam int CAP    = MEM_WORDS * WORD_BITS;

    state_t state_reg, state_next;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] size_reg, size_next;

    logic [3:0]        act_reg;
    logic [14:0]       idx_reg;
    logic [30:0]       val_reg;
    logic [15:0]       cnt_reg;
    logic [1:0]        status_reg;
    logic [30:0]       rd_data_reg;
    logic [30:0]       item_reg;
    phase_t            phase_reg;
    upd_t              upd_reg;
    logic [FILL_W-1:0] src_reg;
    logic [FILL_W-1:0] dst_reg;
    logic [FILL_W-1:0] pos_reg;
    logic [FILL_W-1:0] left_reg;
    logic [FILL_W-1:0] n_reg;
    logic [FILL_W-1:0] nk_reg;
    logic [FILL_W-1:0] k_ext;

    logic [30:0] item_mask;
    logic [63:0] rd_pair;
    logic [30:0] src_item;
    logic [30:0] new_val;
    logic [63:0] m64;
    logic [63:0] d64;
    logic [63:0] merged;

    // request checks
    logic [31:0] size_w, fill_w, idx_w, cnt_w, n_w, nk_w, pos_w, cap_w;
    logic [20:0] nk_p;
    logic [19:0] pos_p;
    logic        wide;
    logic        full;
    logic [1:0]  chk_status;
    logic        chk_go;
    phase_t      chk_phase;
    upd_t        chk_upd;
    logic [31:0] chk_left;
    logic [31:0] chk_src;
    logic [31:0] chk_dst;

    assign item_mask = ~(31'h7FFF_FFFF << k);
    assign k_ext     = FILL_W'(k);
    assign rd_pair   = {mem_rd_hi, mem_rd_lo};
    assign src_item  = 31'(rd_pair >> src_reg[4:0]) & item_mask;

    assign size_w = 32'(size_reg);
    assign fill_w = 32'(fill_reg);
    assign idx_w  = 32'(idx_reg);
    assign cnt_w  = 32'(cnt_reg);
    assign n_w    = (act_reg == ACT_INS_VAL || act_reg == ACT_APPEND) ? 32'd1 : cnt_w;
    assign nk_p   = 21'(n_w) * 21'(k);
    assign pos_p  = 20'(idx_reg) * 20'(k);
    assign nk_w   = 32'(nk_p);
    assign pos_w  = 32'(pos_p);
    assign cap_w  = 32'(CAP);
    assign wide   = ((val_reg & ~item_mask) != '0);
    assign full   = ((fill_w + nk_w) > cap_w);

    always_comb
    begin
        chk_status = ST_OK;
        chk_go     = 1'b0;
        chk_phase  = PH_FIELD;
        chk_upd    = UPD_NONE;
        chk_left   = 32'd1;
        chk_src    = pos_w;
        chk_dst    = pos_w;
        unique case (act_reg)
            ACT_READ, ACT_WRITE, ACT_OR, ACT_AND, ACT_XOR:
            begin
                if (idx_w >= size_w)
                begin
                    chk_status = ST_INDEX;
                end
                else if (act_reg != ACT_READ && wide)
                begin
                    chk_status = ST_WIDE;
                end
                else
                begin
                    chk_go = 1'b1;
                end
            end
            ACT_APPEND:
            begin
                if (wide)
                begin
                    chk_status = ST_WIDE;
                end
                else if (full)
                begin
                    chk_status = ST_FULL;
                end
                else
                begin
                    chk_go    = 1'b1;
                    chk_phase = PH_FILL;
                    chk_upd   = UPD_GROW;
                    chk_dst   = fill_w;
                end
            end
            ACT_INS_ZERO, ACT_INS_VAL:
            begin
                if (idx_w > size_w)
                begin
                    chk_status = ST_INDEX;
                end
                else if (act_reg == ACT_INS_VAL && wide)
                begin
                    chk_status = ST_WIDE;
                end
                else if (full)
                begin
                    chk_status = ST_FULL;
                end
                else if (n_w != '0)
                begin
                    chk_go  = 1'b1;
                    chk_upd = UPD_GROW;
                    if (size_w > idx_w)
                    begin
                        // walk the tail downwards, last item first
                        chk_phase = PH_DOWN;
                        chk_left  = size_w - idx_w;
                        chk_src   = fill_w - 32'(k);
                        chk_dst   = fill_w - 32'(k) + nk_w;
                    end
                    else
                    begin
                        chk_phase = PH_FILL;
                        chk_left  = n_w;
                    end
                end
            end
            ACT_REMOVE:
            begin
                if (idx_w + cnt_w > size_w)
                begin
                    chk_status = ST_INDEX;
                end
                else if (cnt_w != '0)
                begin
                    chk_upd = UPD_SHRINK;
                    if (size_w > idx_w + cnt_w)
                    begin
                        chk_go    = 1'b1;
                        chk_phase = PH_UP;
                        chk_left  = size_w - idx_w - cnt_w;
                        chk_src   = pos_w + nk_w;
                    end
                end
            end
            default:
            begin
                chk_status = ST_OK;
            end
        endcase
    end

    // value written in the write cycle, merged into the destination pair
    always_comb
    begin
        unique case (phase_reg)
            PH_FIELD:
            begin
                unique case (act_reg)
                    ACT_WRITE: new_val = val_reg;
                    ACT_OR:    new_val = item_reg | val_reg;
                    ACT_AND:   new_val = item_reg & val_reg;
                    ACT_XOR:   new_val = item_reg ^ val_reg;
                    default:   new_val = item_reg;
                endcase
            end
            PH_DOWN, PH_UP: new_val = item_reg;
            PH_FILL:        new_val = (act_reg == ACT_INS_ZERO) ? '0 : val_reg;
            default:        new_val = item_reg;
        endcase
        m64    = 64'(item_mask) << dst_reg[4:0];
        d64    = 64'(new_val & item_mask) << dst_reg[4:0];
        merged = (rd_pair & ~m64) | d64;
    end

    always_comb
    begin
        unique case (upd_reg)
            UPD_GROW:
            begin
                size_next = size_reg + n_reg;
                fill_next = fill_reg + nk_reg;
            end
            UPD_SHRINK:
            begin
                size_next = size_reg - n_reg;
                fill_next = fill_reg - nk_reg;
            end
            default:
            begin
                size_next = size_reg;
                fill_next = fill_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!chk_go)
                begin
                    state_next = S_FIN;
                end
                else if (chk_phase == PH_FILL)
                begin
                    state_next = S_DST;
                end
                else
                begin
                    state_next = S_SRC;
                end
            end
            S_SRC:
            begin
                state_next = S_DST;
            end
            S_DST:
            begin
                state_next = (act_reg == ACT_READ) ? S_FIN : S_WR;
            end
            S_WR:
            begin
                if (left_reg == FILL_W'(1))
                begin
                    state_next = (phase_reg == PH_DOWN) ? S_DST : S_FIN;
                end
                else
                begin
                    state_next = (phase_reg == PH_FILL) ? S_DST : S_SRC;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        done           = 1'b0;
        mem_ctl.rd_en  = 1'b0;
        mem_ctl.wr_en  = 1'b0;
        mem_word       = WORD_W'(dst_reg >> 5);
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SRC:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_word      = WORD_W'(src_reg >> 5);
            end
            S_DST:
            begin
                mem_ctl.rd_en = (act_reg != ACT_READ);
            end
            S_WR:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            S_FIN:
            begin
                done = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        mem_wr_lo      = merged[31:0];
        mem_wr_hi      = merged[63:32];
        res.read_data  = rd_data_reg;
        res.status     = status_reg;
        res.item_count = 16'(size_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_clear || (state_reg == S_CHECK && act_reg == ACT_CLEAR))
            begin
                fill_reg <= '0;
                size_reg <= '0;
            end
            else if (state_reg == S_FIN && out_free)
            begin
                fill_reg <= fill_next;
                size_reg <= size_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_reg <= action;
                    idx_reg <= index;
                    val_reg <= value;
                    cnt_reg <= count;
                end
            end
            S_CHECK:
            begin
                status_reg  <= chk_status;
                rd_data_reg <= '0;
                phase_reg   <= chk_phase;
                upd_reg     <= chk_upd;
                left_reg    <= FILL_W'(chk_left);
                src_reg     <= FILL_W'(chk_src);
                dst_reg     <= FILL_W'(chk_dst);
                pos_reg     <= FILL_W'(pos_w);
                n_reg       <= FILL_W'(n_w);
                nk_reg      <= FILL_W'(nk_w);
            end
            S_DST:
            begin
                if (phase_reg != PH_FILL)
                begin
                    item_reg <= src_item;
                end
                if (act_reg == ACT_READ)
                begin
                    rd_data_reg <= src_item;
                end
            end
            S_WR:
            begin
                if (left_reg == FILL_W'(1) && phase_reg == PH_DOWN)
                begin
                    // tail is shifted: fill the opened gap
                    phase_reg <= PH_FILL;
                    left_reg  <= n_reg;
                    dst_reg   <= pos_reg;
                end
                else
                begin
                    left_reg <= left_reg - FILL_W'(1);
                    unique case (phase_reg)
                        PH_DOWN:
                        begin
                            src_reg <= src_reg - k_ext;
                            dst_reg <= dst_reg - k_ext;
                        end
                        PH_UP:
                        begin
                            src_reg <= src_reg + k_ext;
                            dst_reg <= dst_reg + k_ext;
                        end
                        PH_FILL:
                        begin
                            dst_reg <= dst_reg + k_ext;
                        end
                        default:
                        begin
                            dst_reg <= dst_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                item_reg <= item_reg;
            end
        endcase
    end

    a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(CAP))
        else $error("fill point beyond memory capacity");

    a_fill_matches_size: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) == 32'(size_reg) * 32'(k))
        else $error("fill point and item count disagree");

    a_no_empty_move: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR |-> left_reg != '0)
        else $error("write issued with no move left");

    a_read_never_writes: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> act_reg != ACT_READ)
        else $error("read request wrote the memory");

endmodule
